@@ rtl/core/tmc_pkg.sv @@
// tcp mss clamp: shared constants, codes and the decision type
// passed from the parser to the result stage; no dependencies
`default_nettype none

package tmc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CLAMP_WIDTH     = 11;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IPV4_MSS_CLAMP = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IPV6_MSS_CLAMP = 8'd1;

   localparam logic [CLAMP_WIDTH-1:0] IPV4_CLAMP_MIN = 11'd536;
   localparam logic [CLAMP_WIDTH-1:0] IPV4_CLAMP_MAX = 11'd1460;
   localparam logic [CLAMP_WIDTH-1:0] IPV6_CLAMP_MIN = 11'd516;
   localparam logic [CLAMP_WIDTH-1:0] IPV6_CLAMP_MAX = 11'd1440;

   localparam logic [5:0] IPV6_HDR_LEN = 6'd40;
   localparam logic [7:0] TCP_PROTO    = 8'd6;

   // tcp option kinds
   localparam logic [7:0] OPT_EOL     = 8'd0;
   localparam logic [7:0] OPT_NOP     = 8'd1;
   localparam logic [7:0] OPT_MSS     = 8'd2;
   localparam logic [7:0] OPT_MSS_LEN = 8'd4;

   typedef struct packed {
      logic                   valid;
      logic                   rewrite;
      logic [6:0]             mss_offset;
      logic [15:0]            old_mss;
      logic [CLAMP_WIDTH-1:0] clamp;
      logic [15:0]            held_checksum;
   } tmc_decision_type;

endpackage

`default_nettype wire

@@ rtl/core/tmc_intf.sv @@
// tcp mss clamp: valid/ready channel interfaces for packet bytes,
// results and configuration writes; depends on tmc_pkg
`default_nettype none

interface tmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_ipv6;
   logic       last_byte;

   modport source (output valid, data_byte, is_ipv6, last_byte, input ready);
   modport sink   (input valid, data_byte, is_ipv6, last_byte, output ready);
endinterface

interface tmc_rsp_if;
   logic        valid;
   logic        ready;
   logic        rewrite;
   logic [6:0]  mss_offset;
   logic [15:0] old_mss;
   logic [15:0] new_mss;
   logic [15:0] new_checksum;

   modport source (output valid, rewrite, mss_offset, old_mss, new_mss, new_checksum,
                   input ready);
   modport sink   (input valid, rewrite, mss_offset, old_mss, new_mss, new_checksum,
                   output ready);
endinterface

interface tmc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tmc_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [tmc_pkg::CLAMP_WIDTH-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tmc_csr.sv @@
// tcp mss clamp: per-version clamp registers with range-checked writes
// depends on tmc_pkg and tmc_csr_if
`default_nettype none

module tmc_csr (
   input  wire                               clock,
   input  wire                               reset,
   tmc_csr_if.sink                           csr_if,
   output logic [tmc_pkg::CLAMP_WIDTH-1:0]   ipv4_clamp,
   output logic [tmc_pkg::CLAMP_WIDTH-1:0]   ipv6_clamp
);
   import tmc_pkg::*;

   logic [CLAMP_WIDTH-1:0] ipv4_clamp_ff;
   logic [CLAMP_WIDTH-1:0] ipv6_clamp_ff;

   assign csr_if.ready = 1'b1;
   assign ipv4_clamp   = ipv4_clamp_ff;
   assign ipv6_clamp   = ipv6_clamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv4_clamp_ff <= '0;
         ipv6_clamp_ff <= '0;
      end else if (csr_if.valid) begin
         // out-of-range values and unknown indexes are dropped
         case (csr_if.index)
            CSR_IPV4_MSS_CLAMP: begin
               if (csr_if.wdata inside {[IPV4_CLAMP_MIN:IPV4_CLAMP_MAX]})
                  ipv4_clamp_ff <= csr_if.wdata;
            end
            CSR_IPV6_MSS_CLAMP: begin
               if (csr_if.wdata inside {[IPV6_CLAMP_MIN:IPV6_CLAMP_MAX]})
                  ipv6_clamp_ff <= csr_if.wdata;
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tmc_parse.sv @@
// tcp mss clamp: input register and per-byte header / option walk
// depends on tmc_pkg and tmc_req_if
`default_nettype none

module tmc_parse (
   input  wire                               clock,
   input  wire                               reset,
   tmc_req_if.sink                           req_if,
   input  wire [tmc_pkg::CLAMP_WIDTH-1:0]    ipv4_clamp,
   input  wire [tmc_pkg::CLAMP_WIDTH-1:0]    ipv6_clamp,
   input  wire                               res_free,
   output tmc_pkg::tmc_decision_type         dec
);
   import tmc_pkg::*;

   typedef enum logic [1:0] {
      PH_KIND,
      PH_LEN,
      PH_MSS_HI,
      PH_MSS_LO
   } phase_type;

   // input register
   logic       hold_valid_ff;
   logic [7:0] data_ff;
   logic       v6_ff;
   logic       last_ff;

   // packet state
   logic [6:0]  pos_ff,      pos_in;
   logic [5:0]  iphl_ff,     iphl_in;
   logic        is_tcp_ff,   is_tcp_in;
   logic [5:0]  thl_ff,      thl_in;
   logic        syn_ff,      syn_in;
   logic [15:0] csum_ff,     csum_in;
   phase_type   phase_ff,    phase_in;
   logic [6:0]  next_opt_ff, next_opt_in;
   logic [7:0]  kind_ff,     kind_in;
   logic [15:0] mss_ff,      mss_in;
   logic [6:0]  mss_pos_ff,  mss_pos_in;
   logic        done_ff,     done_in;

   logic                   advance;
   logic [7:0]             hdr_base;
   logic [7:0]             pos_ext;
   logic [7:0]             tcp_end;
   logic [8:0]             skip_to;
   logic [CLAMP_WIDTH-1:0] clamp;

   assign advance      = hold_valid_ff && (!last_ff || res_free);
   assign req_if.ready = !hold_valid_ff || advance;

   always_comb begin
      iphl_in     = iphl_ff;
      is_tcp_in   = is_tcp_ff;
      thl_in      = thl_ff;
      syn_in      = syn_ff;
      csum_in     = csum_ff;
      phase_in    = phase_ff;
      next_opt_in = next_opt_ff;
      kind_in     = kind_ff;
      mss_in      = mss_ff;
      mss_pos_in  = mss_pos_ff;
      done_in     = done_ff;
      skip_to     = '0;

      if (pos_ff == 7'd0) begin
         iphl_in     = v6_ff ? IPV6_HDR_LEN : {data_ff[3:0], 2'b00};
         next_opt_in = {1'b0, iphl_in} + 7'd20;
         phase_in    = PH_KIND;
      end
      if ((!v6_ff && pos_ff == 7'd9) || (v6_ff && pos_ff == 7'd6))
         is_tcp_in = (data_ff == TCP_PROTO) && (iphl_in >= 6'd20);

      hdr_base = {2'b00, iphl_in};
      pos_ext  = {1'b0, pos_ff};
      if (pos_ext == hdr_base + 8'd12) thl_in = {data_ff[7:4], 2'b00};
      if (pos_ext == hdr_base + 8'd13) syn_in = data_ff[1];
      if (pos_ext == hdr_base + 8'd16) csum_in[15:8] = data_ff;
      if (pos_ext == hdr_base + 8'd17) csum_in[7:0]  = data_ff;
      tcp_end = hdr_base + {2'b00, thl_in};

      // option walk, only on bytes inside the tcp options area
      if (is_tcp_in && syn_in && !done_in && pos_ext >= hdr_base + 8'd20
          && pos_ext < tcp_end) begin
         case (phase_in)
            PH_KIND: begin
               if (pos_ff == next_opt_in) begin
                  if (data_ff == OPT_EOL) begin
                     done_in = 1'b1;
                  end else if (data_ff == OPT_NOP) begin
                     next_opt_in = pos_ff + 7'd1;
                  end else begin
                     kind_in  = data_ff;
                     phase_in = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               if (kind_in == OPT_MSS) begin
                  if (data_ff == OPT_MSS_LEN) begin
                     phase_in   = PH_MSS_HI;
                     mss_pos_in = pos_ff + 7'd1;
                  end else begin
                     done_in = 1'b1;
                  end
               end else if (data_ff < 8'd2) begin
                  done_in = 1'b1;
               end else begin
                  skip_to = {2'b00, pos_ff} + {1'b0, data_ff} - 9'd1;
                  if (skip_to >= {1'b0, tcp_end}) begin
                     done_in = 1'b1;
                  end else begin
                     next_opt_in = skip_to[6:0];
                     phase_in    = PH_KIND;
                  end
               end
            end
            PH_MSS_HI: begin
               // kind register doubles as the mss high byte
               kind_in  = data_ff;
               phase_in = PH_MSS_LO;
            end
            PH_MSS_LO: begin
               mss_in  = {kind_in, data_ff};
               done_in = 1'b1;
            end
            default: done_in = 1'b1;
         endcase
      end

      pos_in = (pos_ff == 7'd127) ? pos_ff : pos_ff + 7'd1;
   end

   assign clamp = v6_ff ? ipv6_clamp : ipv4_clamp;

   always_comb begin
      dec.valid         = advance && last_ff;
      dec.rewrite       = is_tcp_in && syn_in && (clamp != '0) && (thl_in > 6'd20)
                          && (mss_in > {5'b0, clamp});
      dec.mss_offset    = mss_pos_in;
      dec.old_mss       = mss_in;
      dec.clamp         = clamp;
      dec.held_checksum = csum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         hold_valid_ff <= req_if.valid;
      end
      if (req_if.ready) begin
         data_ff <= req_if.data_byte;
         v6_ff   <= req_if.is_ipv6;
         last_ff <= req_if.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last_ff)) begin
         pos_ff      <= '0;
         iphl_ff     <= '0;
         is_tcp_ff   <= 1'b0;
         thl_ff      <= '0;
         syn_ff      <= 1'b0;
         csum_ff     <= '0;
         phase_ff    <= PH_KIND;
         next_opt_ff <= '0;
         kind_ff     <= '0;
         mss_ff      <= '0;
         mss_pos_ff  <= '0;
         done_ff     <= 1'b0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         iphl_ff     <= iphl_in;
         is_tcp_ff   <= is_tcp_in;
         thl_ff      <= thl_in;
         syn_ff      <= syn_in;
         csum_ff     <= csum_in;
         phase_ff    <= phase_in;
         next_opt_ff <= next_opt_in;
         kind_ff     <= kind_in;
         mss_ff      <= mss_in;
         mss_pos_ff  <= mss_pos_in;
         done_ff     <= done_in;
      end
   end

   // a packet end is only processed when the result stage has room
   a_dec_has_room: assert property (@(posedge clock) disable iff (reset)
      dec.valid |-> res_free)
      else $error("packet decision issued while result stage full");

   // packet state starts over after the final byte
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      dec.valid |=> (pos_ff == 7'd0) && !done_ff && (mss_ff == 16'd0))
      else $error("packet state not cleared after last byte");

endmodule

`default_nettype wire

@@ rtl/core/tmc_result.sv @@
// tcp mss clamp: incremental checksum update and result output register
// depends on tmc_pkg and tmc_rsp_if
`default_nettype none

module tmc_result (
   input  wire                          clock,
   input  wire                          reset,
   input  tmc_pkg::tmc_decision_type    dec,
   output logic                         res_free,
   tmc_rsp_if.source                    rsp_if
);
   import tmc_pkg::*;

   logic        valid_ff;
   logic        rewrite_ff;
   logic [6:0]  offset_ff;
   logic [15:0] old_mss_ff;
   logic [15:0] new_mss_ff;
   logic [15:0] csum_ff;

   logic [17:0] sum_raw;
   logic [16:0] sum_fold1;
   logic [15:0] sum_fold2;
   logic [15:0] csum_new;

   // ones-complement update: ~(~hc + ~m + m')
   always_comb begin
      sum_raw   = {2'b00, ~dec.held_checksum} + {2'b00, ~dec.old_mss}
                  + {7'b0, dec.clamp};
      sum_fold1 = {1'b0, sum_raw[15:0]} + {15'b0, sum_raw[17:16]};
      sum_fold2 = sum_fold1[15:0] + {15'b0, sum_fold1[16]};
      csum_new  = ~sum_fold2;
   end

   assign res_free = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (dec.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         valid_ff <= 1'b0;
      end
      if (dec.valid) begin
         rewrite_ff <= dec.rewrite;
         offset_ff  <= dec.rewrite ? dec.mss_offset : '0;
         old_mss_ff <= dec.old_mss;
         new_mss_ff <= dec.rewrite ? {5'b0, dec.clamp} : '0;
         csum_ff    <= dec.rewrite ? csum_new : '0;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.rewrite      = rewrite_ff;
   assign rsp_if.mss_offset   = offset_ff;
   assign rsp_if.old_mss      = old_mss_ff;
   assign rsp_if.new_mss      = new_mss_ff;
   assign rsp_if.new_checksum = csum_ff;

   a_rewrite_lowers: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.rewrite |->
         (rsp_if.new_mss != 16'd0) && (rsp_if.new_mss < rsp_if.old_mss))
      else $error("rewrite does not lower the mss");

   a_no_rewrite_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.rewrite |->
         (rsp_if.new_mss == 16'd0) && (rsp_if.new_checksum == 16'd0)
         && (rsp_if.mss_offset == 7'd0))
      else $error("fields not zero without rewrite");

endmodule

`default_nettype wire

@@ rtl/core/tcp_mss_clamp_top.sv @@
// tcp mss clamp top: one packet byte per transaction, one result per packet
// a last byte waits in the input register for room in the result stage's output register
// throughput: one byte per cycle; a last byte waits only while an earlier result is held
// and not taken
// reset: clamps read 0 (disabled), packet state and both channels empty
// depends on tmc_pkg, tmc_intf, tmc_csr, tmc_parse and tmc_result
`default_nettype none

module tcp_mss_clamp_top (
   input  wire        clock,
   input  wire        reset,
   tmc_req_if.sink    req_if,
   tmc_rsp_if.source  rsp_if,
   tmc_csr_if.sink    csr_if
);
   import tmc_pkg::*;

   logic [CLAMP_WIDTH-1:0] ipv4_clamp;
   logic [CLAMP_WIDTH-1:0] ipv6_clamp;
   logic                   res_free;
   tmc_decision_type       dec;

   tmc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_if     (csr_if),
      .ipv4_clamp (ipv4_clamp),
      .ipv6_clamp (ipv6_clamp)
   );

   tmc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .ipv4_clamp (ipv4_clamp),
      .ipv6_clamp (ipv6_clamp),
      .res_free   (res_free),
      .dec        (dec)
   );

   tmc_result u_result (
      .clock    (clock),
      .reset    (reset),
      .dec      (dec),
      .res_free (res_free),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for tcp_mss_clamp_top: streams IPv4/IPv6 packet bytes, predicts the
// per-packet clamp decision and checksum patch, and checks every result in order
// depends on tmc_pkg, tmc_intf and the tcp_mss_clamp_top rtl
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tmc_pkg::*;

   localparam logic [7:0] TCP_FLAG_SYN  = 8'h02;
   localparam logic [7:0] TCP_FLAG_ACK  = 8'h10;
   localparam logic [7:0] UDP_PROTO     = 8'd17;
   localparam logic [7:0] OPT_WSCALE    = 8'd3;
   localparam logic [7:0] OPT_TIMESTAMP = 8'd8;

   typedef struct packed {
      logic        rewrite;
      logic [6:0]  mss_offset;
      logic [15:0] old_mss;
      logic [15:0] new_mss;
      logic [15:0] new_checksum;
   } clamp_result_type;

   typedef enum logic [1:0] {
      OPT_AT_KIND,
      OPT_AT_LEN,
      OPT_AT_MSS_HI,
      OPT_AT_MSS_LO
   } opt_phase_type;

   class mss_clamp_scoreboard;
      logic [CLAMP_WIDTH-1:0] v4_clamp = '0;
      logic [CLAMP_WIDTH-1:0] v6_clamp = '0;

      logic [6:0]    byte_pos  = '0;
      logic [5:0]    ip_hlen   = '0;
      logic          tcp_seen  = 1'b0;
      logic [5:0]    tcp_hlen  = '0;
      logic          syn_seen  = 1'b0;
      logic [15:0]   tcp_csum  = '0;
      opt_phase_type opt_phase = OPT_AT_KIND;
      logic [6:0]    next_opt  = '0;
      logic [7:0]    opt_kind  = '0;
      logic [15:0]   mss_found = '0;
      logic [6:0]    mss_pos   = '0;
      logic          walk_done = 1'b0;

      clamp_result_type clamp_results_due[$];
      int unsigned mismatches    = 0;
      int unsigned results_seen  = 0;
      int unsigned rewrites_seen = 0;

      function int unsigned pending();
         return clamp_results_due.size();
      endfunction

      function void write_clamp(logic [CSR_INDEX_WIDTH-1:0] index,
                                logic [CLAMP_WIDTH-1:0] value);
         if (index == CSR_IPV4_MSS_CLAMP) begin
            if (value >= IPV4_CLAMP_MIN && value <= IPV4_CLAMP_MAX) v4_clamp = value;
         end else if (index == CSR_IPV6_MSS_CLAMP) begin
            if (value >= IPV6_CLAMP_MIN && value <= IPV6_CLAMP_MAX) v6_clamp = value;
         end
      endfunction

      function void clear_packet();
         byte_pos  = '0;
         ip_hlen   = '0;
         tcp_seen  = 1'b0;
         tcp_hlen  = '0;
         syn_seen  = 1'b0;
         tcp_csum  = '0;
         opt_phase = OPT_AT_KIND;
         next_opt  = '0;
         opt_kind  = '0;
         mss_found = '0;
         mss_pos   = '0;
         walk_done = 1'b0;
      endfunction

      // ones-complement patch of the tcp checksum for one replaced 16-bit word
      function logic [15:0] patch_checksum(logic [15:0] hc, logic [15:0] m_old,
                                           logic [15:0] m_new);
         logic [15:0] hc_inv;
         logic [15:0] old_inv;
         int unsigned s;
         hc_inv  = ~hc;
         old_inv = ~m_old;
         s = 32'(hc_inv) + 32'(old_inv) + 32'(m_new);
         s = (s & 32'hffff) + (s >> 16);
         s = (s & 32'hffff) + (s >> 16);
         return ~s[15:0];
      endfunction

      function void walk_option(int unsigned p, logic [7:0] b, int unsigned hdr_end);
         int unsigned nxt;
         case (opt_phase)
            OPT_AT_KIND: begin
               if (p != next_opt) return;
               if (b == OPT_EOL) walk_done = 1'b1;
               else if (b == OPT_NOP) next_opt = 7'(p + 1);
               else begin
                  opt_kind  = b;
                  opt_phase = OPT_AT_LEN;
               end
            end
            OPT_AT_LEN: begin
               if (opt_kind == OPT_MSS) begin
                  if (b == OPT_MSS_LEN) begin
                     opt_phase = OPT_AT_MSS_HI;
                     mss_pos   = 7'(p + 1);
                  end else begin
                     walk_done = 1'b1;
                  end
               end else if (b < 2) begin
                  walk_done = 1'b1;
               end else begin
                  nxt = p - 1 + b;
                  if (nxt >= hdr_end) walk_done = 1'b1;
                  else begin
                     next_opt  = 7'(nxt);
                     opt_phase = OPT_AT_KIND;
                  end
               end
            end
            OPT_AT_MSS_HI: begin
               opt_kind  = b;
               opt_phase = OPT_AT_MSS_LO;
            end
            default: begin
               mss_found = {opt_kind, b};
               walk_done = 1'b1;
            end
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic v6, logic last);
         int unsigned p;
         int unsigned t;
         logic [CLAMP_WIDTH-1:0] clamp;
         logic rw;
         clamp_result_type r;
         p = byte_pos;
         if (p == 0) begin
            ip_hlen   = v6 ? IPV6_HDR_LEN : {b[3:0], 2'b00};
            next_opt  = 7'(ip_hlen + 20);
            opt_phase = OPT_AT_KIND;
         end
         if ((!v6 && p == 9) || (v6 && p == 6))
            tcp_seen = (b == TCP_PROTO) && (ip_hlen >= 20);
         t = ip_hlen;
         if (p == t + 12) tcp_hlen = {b[7:4], 2'b00};
         if (p == t + 13) syn_seen = b[1];
         if (p == t + 16) tcp_csum[15:8] = b;
         if (p == t + 17) tcp_csum[7:0] = b;
         if (tcp_seen && syn_seen && !walk_done && p >= t + 20 && p < t + tcp_hlen)
            walk_option(p, b, t + tcp_hlen);
         if (!last) begin
            if (byte_pos < 7'd127) byte_pos++;
            return;
         end
         clamp = v6 ? v6_clamp : v4_clamp;
         rw = tcp_seen && syn_seen && clamp != 0 && tcp_hlen > 20 &&
              mss_found != 0 && mss_found > 16'(clamp);
         r.rewrite      = rw;
         r.mss_offset   = rw ? mss_pos : 7'd0;
         r.old_mss      = mss_found;
         r.new_mss      = rw ? 16'(clamp) : 16'd0;
         r.new_checksum = rw ? patch_checksum(tcp_csum, mss_found, 16'(clamp)) : 16'd0;
         clamp_results_due.push_back(r);
         clear_packet();
      endfunction

      function void check_result(clamp_result_type got);
         clamp_result_type want;
         results_seen++;
         if (got.rewrite) rewrites_seen++;
         if (clamp_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %0d: rewrite=%0b off=%0d old=%h new=%h csum=%h",
                        results_seen, got.rewrite, got.mss_offset, got.old_mss,
                        got.new_mss, got.new_checksum);
            return;
         end
         want = clamp_results_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d at %0t mismatch", results_seen, $realtime);
               $display("  expected rewrite=%0b off=%0d old=%h new=%h csum=%h",
                        want.rewrite, want.mss_offset, want.old_mss, want.new_mss,
                        want.new_checksum);
               $display("  actual   rewrite=%0b off=%0d old=%h new=%h csum=%h",
                        got.rewrite, got.mss_offset, got.old_mss, got.new_mss,
                        got.new_checksum);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   tmc_req_if req_if ();
   tmc_rsp_if rsp_if ();
   tmc_csr_if csr_if ();

   tcp_mss_clamp_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   mss_clamp_scoreboard sb = new;

   logic [7:0]  pkt[$];
   bit          pkt_v6;
   int          hdr_total;
   int unsigned bytes_sent = 0;
   int unsigned pkts_sent  = 0;
   int unsigned csr_writes = 0;

   task automatic send_byte(logic [7:0] b, logic v6, logic last, bit steady);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.is_ipv6   <= v6;
      req_if.last_byte <= last;
      do @(posedge clock); while (!req_if.ready);
      sb.note_byte(b, v6, last);
      bytes_sent++;
   endtask

   task automatic send_packet(bit flip_v6);
      bit steady;
      logic v6;
      int i;
      steady = ($urandom_range(0, 3) == 0);
      for (i = 0; i < pkt.size(); i++) begin
         v6 = flip_v6 ? 1'($urandom_range(0, 1)) : pkt_v6;
         send_byte(pkt[i], v6, i == pkt.size() - 1, steady);
      end
      pkts_sent++;
   endtask

   // hold the sender until every outstanding result has been taken
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index,
                            logic [CLAMP_WIDTH-1:0] value, bit hold);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.wdata <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (!hold) csr_if.valid <= 1'b0;
      sb.write_clamp(index, value);
      csr_writes++;
   endtask

   task automatic set_clamps(int v4, int v6);
      write_csr(CSR_IPV4_MSS_CLAMP, 11'(v4), 1'b1);
      write_csr(CSR_IPV6_MSS_CLAMP, 11'(v6), 1'b0);
   endtask

   // ip header plus the fixed 20-byte tcp header, random filler elsewhere
   task automatic begin_header(bit v6, int ihl, int doff, logic [7:0] flags,
                               logic [7:0] proto);
      int ip_len;
      int i;
      pkt.delete();
      pkt_v6 = v6;
      ip_len = v6 ? 40 : (ihl < 5 ? 20 : ihl * 4);
      for (i = 0; i < ip_len + 20; i++) pkt.push_back(8'($urandom));
      pkt[0] = v6 ? {4'h6, pkt[0][3:0]} : {4'h4, 4'(ihl)};
      pkt[v6 ? 6 : 9] = proto;
      pkt[ip_len + 12] = {4'(doff), pkt[ip_len + 12][3:0]};
      pkt[ip_len + 13] = flags;
      hdr_total = ip_len + doff * 4;
   endtask

   function automatic void add_mss(logic [15:0] value);
      pkt.push_back(OPT_MSS);
      pkt.push_back(OPT_MSS_LEN);
      pkt.push_back(value[15:8]);
      pkt.push_back(value[7:0]);
   endfunction

   task automatic close_packet(int payload, int cut);
      while (pkt.size() < hdr_total) pkt.push_back(8'($urandom));
      repeat (payload) pkt.push_back(8'($urandom));
      if (cut > 0) while (pkt.size() > cut) void'(pkt.pop_back());
   endtask

   task automatic syn_with_mss(bit v6, logic [15:0] mss);
      begin_header(v6, 5, 6, TCP_FLAG_SYN, TCP_PROTO);
      add_mss(mss);
      close_packet(2, 0);
      send_packet(1'b0);
   endtask

   function automatic logic [15:0] pick_mss(bit v6);
      logic [15:0] clamp;
      clamp = 16'(v6 ? sb.v6_clamp : sb.v4_clamp);
      case ($urandom_range(0, 6))
         0: return 16'd0;
         1: return clamp;
         2: return clamp + 16'd1;
         3: return 16'($urandom_range(500, 1500));
         4: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_random_options(int room, bit v6);
      int sel;
      int len;
      int i;
      logic [7:0] bad_len;
      while (room > 0) begin
         sel = $urandom_range(0, 99);
         if (sel < 20) begin
            pkt.push_back(OPT_NOP);
            room--;
         end else if (sel < 55 && room >= 4) begin
            add_mss(pick_mss(v6));
            room -= 4;
         end else if (sel < 72 && room >= 2) begin
            len = $urandom_range(2, room < 12 ? room : 12);
            pkt.push_back(8'($urandom_range(3, 255)));
            pkt.push_back(8'(len));
            for (i = 2; i < len; i++) pkt.push_back(8'($urandom));
            room -= len;
         end else if (sel < 77) begin
            pkt.push_back(OPT_EOL);
            room--;
         end else if (sel < 82 && room >= 2) begin
            pkt.push_back(8'($urandom_range(3, 255)));
            pkt.push_back(8'($urandom_range(0, 1)));
            room -= 2;
         end else if (sel < 87 && room >= 2) begin
            bad_len = 8'($urandom);
            if (bad_len == OPT_MSS_LEN) bad_len = 8'd5;
            pkt.push_back(OPT_MSS);
            pkt.push_back(bad_len);
            room -= 2;
         end else if (sel < 92 && room >= 2) begin
            // length runs past the end of the tcp header
            pkt.push_back(8'($urandom_range(3, 255)));
            pkt.push_back(8'(room + $urandom_range(1, 40)));
            room -= 2;
         end else begin
            pkt.push_back(8'($urandom));
            room--;
         end
      end
   endtask

   task automatic random_packet();
      int sel;
      bit v6;
      int ihl;
      int doff;
      logic [7:0] flags;
      logic [7:0] proto;
      int payload;
      int n;
      bit flip;
      sel  = $urandom_range(0, 99);
      flip = 1'b0;
      if (sel >= 80 && sel < 90) begin
         // noise: short random bursts, sometimes with the version bit wandering
         pkt.delete();
         n = $urandom_range(1, 30);
         repeat (n) pkt.push_back(8'($urandom));
         pkt_v6 = 1'($urandom_range(0, 1));
         flip   = ($urandom_range(0, 2) == 0);
      end else begin
         v6    = ($urandom_range(0, 9) < 4);
         ihl   = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(6, 15);
         doff  = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(6, 15);
         flags = 8'($urandom) | TCP_FLAG_SYN;
         proto = TCP_PROTO;
         if (sel >= 90 && sel < 95) begin
            case ($urandom_range(0, 2))
               0: flags = flags & ~TCP_FLAG_SYN;
               1: proto = ($urandom_range(0, 1) == 0) ? UDP_PROTO : 8'($urandom);
               default: begin
                  ihl = $urandom_range(0, 4);
                  v6  = 1'b0;
               end
            endcase
         end
         begin_header(v6, ihl, doff, flags, proto);
         add_random_options(doff * 4 - 20, v6);
         payload = $urandom_range(0, 4);
         if (sel >= 95) payload = (hdr_total < 130 ? 130 - hdr_total : 0) +
                                  $urandom_range(0, 15);
         close_packet(payload, 0);
         if (sel >= 65 && sel < 80) begin
            if ($urandom_range(0, 1) == 0)
               pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
            else
               close_packet(0, $urandom_range(1, pkt.size() - 1));
         end
      end
      send_packet(flip);
      if ($urandom_range(0, 9) == 0) drain_results();
   endtask

   task automatic run_random(int unsigned byte_goal, int unsigned pkt_goal);
      int unsigned byte_stop;
      int unsigned pkt_stop;
      byte_stop = bytes_sent + byte_goal;
      pkt_stop  = pkts_sent + pkt_goal;
      while (bytes_sent < byte_stop || pkts_sent < pkt_stop) random_packet();
   endtask

   task automatic run_directed();
      int i;
      // clamps still disabled from reset
      syn_with_mss(1'b0, 16'hffff);
      syn_with_mss(1'b1, 16'd1500);
      drain_results();
      write_csr(CSR_IPV4_MSS_CLAMP, 11'd0, 1'b1);
      write_csr(CSR_IPV4_MSS_CLAMP, IPV4_CLAMP_MIN - 11'd1, 1'b1);
      write_csr(CSR_IPV4_MSS_CLAMP, IPV4_CLAMP_MIN, 1'b1);
      write_csr(CSR_IPV6_MSS_CLAMP, IPV6_CLAMP_MIN - 11'd1, 1'b1);
      write_csr(CSR_IPV6_MSS_CLAMP, IPV6_CLAMP_MIN, 1'b1);
      write_csr(8'd2, 11'd1000, 1'b1);
      write_csr(8'hff, 11'h7ff, 1'b0);
      syn_with_mss(1'b0, 16'(IPV4_CLAMP_MIN) + 16'd1);
      syn_with_mss(1'b0, 16'(IPV4_CLAMP_MIN));
      syn_with_mss(1'b1, 16'(IPV6_CLAMP_MIN) + 16'd1);
      syn_with_mss(1'b1, 16'hffff);
      syn_with_mss(1'b0, 16'd0);
      // nop, nop and a timestamp ahead of the mss
      begin_header(1'b0, 5, 9, TCP_FLAG_SYN, TCP_PROTO);
      pkt.push_back(OPT_NOP);
      pkt.push_back(OPT_NOP);
      pkt.push_back(OPT_TIMESTAMP);
      pkt.push_back(8'd10);
      repeat (8) pkt.push_back(8'($urandom));
      add_mss(16'd1400);
      close_packet(0, 0);
      send_packet(1'b0);
      // end of option list hides the mss
      begin_header(1'b0, 5, 7, TCP_FLAG_SYN, TCP_PROTO);
      pkt.push_back(OPT_EOL);
      add_mss(16'd2000);
      close_packet(1, 0);
      send_packet(1'b0);
      // option length below two
      begin_header(1'b0, 5, 7, TCP_FLAG_SYN, TCP_PROTO);
      pkt.push_back(OPT_WSCALE);
      pkt.push_back(8'd1);
      add_mss(16'd2000);
      close_packet(0, 0);
      send_packet(1'b0);
      // mss option with the wrong length
      begin_header(1'b0, 5, 7, TCP_FLAG_SYN, TCP_PROTO);
      pkt.push_back(OPT_MSS);
      pkt.push_back(8'd3);
      pkt.push_back(8'd7);
      pkt.push_back(8'd208);
      add_mss(16'd2000);
      close_packet(0, 0);
      send_packet(1'b0);
      // ihl below five, then a non-tcp protocol, then no syn
      begin_header(1'b0, 3, 6, TCP_FLAG_SYN, TCP_PROTO);
      add_mss(16'd4000);
      close_packet(0, 0);
      send_packet(1'b0);
      begin_header(1'b0, 5, 6, TCP_FLAG_SYN, UDP_PROTO);
      add_mss(16'd4000);
      close_packet(0, 0);
      send_packet(1'b0);
      begin_header(1'b0, 5, 6, TCP_FLAG_ACK, TCP_PROTO);
      add_mss(16'd4000);
      close_packet(0, 0);
      send_packet(1'b0);
      // no option space at all
      begin_header(1'b0, 5, 5, TCP_FLAG_SYN, TCP_PROTO);
      add_mss(16'd4000);
      close_packet(0, 0);
      send_packet(1'b0);
      // largest headers, mss in the last option slot
      begin_header(1'b0, 15, 15, 8'hff, TCP_PROTO);
      for (i = 0; i < 36; i++) pkt.push_back(OPT_NOP);
      add_mss(16'd9000);
      close_packet(0, 0);
      send_packet(1'b0);
      // option length runs past the header end
      begin_header(1'b0, 5, 6, TCP_FLAG_SYN, TCP_PROTO);
      pkt.push_back(OPT_TIMESTAMP);
      pkt.push_back(8'd10);
      close_packet(8, 0);
      send_packet(1'b0);
      // mss value bytes would fall beyond the header end
      begin_header(1'b0, 5, 7, TCP_FLAG_SYN, TCP_PROTO);
      pkt.push_back(OPT_WSCALE);
      pkt.push_back(8'd6);
      repeat (4) pkt.push_back(8'($urandom));
      add_mss(16'd3000);
      close_packet(0, 0);
      send_packet(1'b0);
      // packet cut after the mss high byte
      begin_header(1'b0, 5, 6, TCP_FLAG_SYN, TCP_PROTO);
      add_mss(16'd3000);
      close_packet(0, 43);
      send_packet(1'b0);
      // long packet saturates the byte position
      begin_header(1'b1, 5, 6, TCP_FLAG_SYN, TCP_PROTO);
      add_mss(16'd3000);
      close_packet(100, 0);
      send_packet(1'b0);
      // version bit changing mid packet, then a one-byte packet
      begin_header(1'b0, 5, 6, TCP_FLAG_SYN, TCP_PROTO);
      add_mss(16'd3000);
      close_packet(0, 0);
      send_packet(1'b1);
      pkt.delete();
      pkt.push_back(8'h45);
      send_packet(1'b0);
      drain_results();
      set_clamps(IPV4_CLAMP_MAX, IPV6_CLAMP_MAX);
      syn_with_mss(1'b0, 16'(IPV4_CLAMP_MAX) + 16'd1);
      syn_with_mss(1'b1, 16'(IPV6_CLAMP_MAX) + 16'd1);
      syn_with_mss(1'b1, 16'(IPV6_CLAMP_MAX));
   endtask

   initial begin : stimulus
      int phase_idx;
      int k;
      int sel;
      logic [CSR_INDEX_WIDTH-1:0] index;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.is_ipv6   <= 1'b0;
      req_if.last_byte <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= '0;
      csr_if.wdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         drain_results();
         case (phase_idx)
            0: set_clamps(IPV4_CLAMP_MAX, IPV6_CLAMP_MAX);
            1: set_clamps($urandom_range(IPV4_CLAMP_MIN, IPV4_CLAMP_MAX),
                          $urandom_range(IPV6_CLAMP_MIN, IPV6_CLAMP_MAX));
            2: begin
               // raw writes, many of them out of range or to unused indexes
               for (k = 0; k < 4; k++) begin
                  sel   = $urandom_range(0, 2);
                  index = (sel == 0) ? CSR_IPV4_MSS_CLAMP :
                          (sel == 1) ? CSR_IPV6_MSS_CLAMP :
                                       CSR_INDEX_WIDTH'($urandom_range(2, 255));
                  write_csr(index, CLAMP_WIDTH'($urandom), k < 3);
               end
            end
            default: begin
               write_csr(CSR_IPV4_MSS_CLAMP, IPV4_CLAMP_MIN, 1'b1);
               write_csr(CSR_IPV6_MSS_CLAMP, IPV6_CLAMP_MAX, 1'b1);
               set_clamps(0, 0);
            end
         endcase
         run_random(30, 1);
      end
      drain_results();
      repeat (6) @(posedge clock);
      $display("covered %0d packets in %0d bytes, %0d results checked, %0d rewrites",
               pkts_sent, bytes_sent, sb.results_seen, sb.rewrites_seen);
      $display("clamp registers took %0d writes: reset, both range edges, random values",
               csr_writes);
      if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tcp_mss_clamp_top verification clean");
      end else begin
         $display("%0d bad results", sb.mismatches);
         $display("tcp_mss_clamp_top verification failed");
      end
      $finish;
   end

   initial begin : result_sink
      int unsigned stall;
      bit steady;
      clamp_result_type got;
      rsp_if.ready <= 1'b0;
      steady = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         stall = steady ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.rewrite      = rsp_if.rewrite;
         got.mss_offset   = rsp_if.mss_offset;
         got.old_mss      = rsp_if.old_mss;
         got.new_mss      = rsp_if.new_mss;
         got.new_checksum = rsp_if.new_checksum;
         sb.check_result(got);
      end
   end

   initial begin : watchdog
      #1000000;
      $display("run did not finish in time");
      $display("tcp_mss_clamp_top verification failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/tmc_pkg.sv
rtl/core/tmc_intf.sv
rtl/core/tmc_csr.sv
rtl/core/tmc_parse.sv
rtl/core/tmc_result.sv
rtl/core/tcp_mss_clamp_top.sv
tb/sv/tb.sv
